// File: rtl/sha1sh_pkg.sv
// Shared types and constants of the SHA-1 stream hasher.
`default_nettype none

package sha1sh_pkg;

	localparam int unsigned CMDQ_DEPTH_DEF = 4;
	localparam int unsigned BYTE_CNT_W = 61;
	localparam int unsigned DIGEST_WORDS = 5;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hEFCDAB89;
	localparam logic [31:0] IV2 = 32'h98BADCFE;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [2:0] LAST_INDEX = 3'd4;

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       byte_present;
		logic       end_of_message;
	} in_word_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_word_t;

	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       eom;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t cmd;
	} cmd_push_t;

	typedef struct packed {
		logic empty;
		cmd_t cmd;
	} cmd_head_t;

endpackage

`default_nettype wire

// File: rtl/sha1sh_front.sv
// Front stage: takes input words, drops idle words and forwards commands.
`default_nettype none

module sha1sh_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  sha1sh_pkg::in_word_t item,
	output sha1sh_pkg::cmd_push_t q_push,
	input  logic                 q_full
);
	import sha1sh_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	logic take;
	logic useful;

	assign useful = item.byte_present | item.end_of_message;
	assign full = valid_s1 & q_full;
	assign take = push & ~full;

	assign q_push.push = valid_s1 & ~q_full;
	assign q_push.cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= useful;
		end else if (!q_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.data <= item.msg_byte;
			cmd_s1.has_byte <= item.byte_present;
			cmd_s1.eom <= item.end_of_message;
		end
	end

endmodule

`default_nettype wire

// File: rtl/sha1sh_cmdq.sv
// Short command queue between the front stage and the hash engine.
`default_nettype none

module sha1sh_cmdq #(
	parameter int unsigned DEPTH = sha1sh_pkg::CMDQ_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha1sh_pkg::cmd_push_t wr,
	output logic                  full,
	output sha1sh_pkg::cmd_head_t head,
	input  logic                  pop
);
	import sha1sh_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full = (cnt_q == CNT_FULL);
	assign head.empty = (cnt_q == '0);
	assign head.cmd = mem_q[rd_ptr_q];
	assign do_wr = wr.push & ~full;
	assign do_rd = pop & ~head.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr.cmd;
		end
	end

endmodule

`default_nettype wire

// File: rtl/sha1sh_engine.sv
// Hash engine: block window, padding sequencer, round unit and digest output bank.
`default_nettype none

module sha1sh_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha1sh_pkg::cmd_head_t head,
	output logic                  q_pop,
	output logic                  empty,
	input  logic                  pop,
	output sha1sh_pkg::out_word_t result
);
	import sha1sh_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PAD   = 3'd1;
	localparam logic [2:0] S_ROUND = 3'd2;
	localparam logic [2:0] S_ADD   = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	localparam logic [5:0] FILL_LAST = 6'd63;
	localparam logic [5:0] LEN_START = 6'd56;
	localparam logic [6:0] RND_LAST = 7'd79;

	logic [2:0]            state_q;
	logic [5:0]            fill_q;
	logic [BYTE_CNT_W-1:0] cnt_q;
	logic [6:0]            rnd_q;
	logic                  pad_q;
	logic                  first_q;
	logic                  len_ok_q;
	logic                  final_q;
	logic [31:0]           h_q [DIGEST_WORDS];
	logic [31:0]           a_q, b_q, c_q, d_q, e_q;
	logic [511:0]          blk_q;
	logic                  out_busy_q;
	logic [2:0]            out_idx_q;
	logic [31:0]           out_q [DIGEST_WORDS];

	logic [63:0]  len_bits;
	logic [63:0]  len_shift;
	logic [5:0]   len_sh;
	logic [7:0]   pad_byte;
	logic [31:0]   w_cur, w_new, f_val, k_val, t_val;
	logic         take_cmd;
	logic         shift_byte;
	logic [7:0]   byte_in;
	logic         start_blk;
	logic         do_round;
	logic         load_out;
	logic         out_take;

	// Length bytes come out most significant first at positions 56 to 63.
	assign len_bits = {cnt_q, 3'b000};
	assign len_sh = {3'd7 - fill_q[2:0], 3'b000};
	assign len_shift = len_bits >> len_sh;

	always_comb begin
		if (first_q) begin
			pad_byte = PAD_MARK;
		end else if (len_ok_q && fill_q >= LEN_START) begin
			pad_byte = len_shift[7:0];
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign take_cmd = (state_q == S_IDLE) & ~head.empty;
	assign q_pop = take_cmd;
	assign shift_byte = (take_cmd & head.cmd.has_byte) | (state_q == S_PAD);
	assign byte_in = (state_q == S_PAD) ? pad_byte : head.cmd.data;
	assign start_blk = shift_byte & (fill_q == FILL_LAST);
	assign do_round = (state_q == S_ROUND);
	assign load_out = (state_q == S_OUT) & ~out_busy_q;
	assign out_take = pop & out_busy_q;

	// The window holds w[t] to w[t+15], oldest in the top word.
	assign w_cur = blk_q[511:480];
	always_comb begin
		logic [31:0] x;
		x = blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ w_cur;
		w_new = {x[30:0], x[31]};
	end

	always_comb begin
		if (rnd_q < 7'd20) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = K0;
		end else if (rnd_q < 7'd40) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K1;
		end else if (rnd_q < 7'd60) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = K2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K3;
		end
	end

	assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			cnt_q <= '0;
			rnd_q <= '0;
			pad_q <= 1'b0;
			first_q <= 1'b0;
			len_ok_q <= 1'b0;
			final_q <= 1'b0;
			h_q[0] <= IV0;
			h_q[1] <= IV1;
			h_q[2] <= IV2;
			h_q[3] <= IV3;
			h_q[4] <= IV4;
			out_busy_q <= 1'b0;
			out_idx_q <= '0;
		end else begin
			if (shift_byte) begin
				fill_q <= fill_q + 1'b1;
			end
			if (take_cmd && head.cmd.has_byte) begin
				cnt_q <= cnt_q + 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take_cmd) begin
						if (head.cmd.eom) begin
							pad_q <= 1'b1;
							first_q <= 1'b1;
						end
						if (start_blk) begin
							state_q <= S_ROUND;
							final_q <= 1'b0;
						end else if (head.cmd.eom) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					first_q <= 1'b0;
					if (first_q && fill_q < LEN_START) begin
						len_ok_q <= 1'b1;
					end
					if (start_blk) begin
						state_q <= S_ROUND;
						final_q <= len_ok_q;
						len_ok_q <= 1'b1;
					end
				end
				S_ROUND: begin
					if (rnd_q == RND_LAST) begin
						rnd_q <= '0;
						state_q <= S_ADD;
					end else begin
						rnd_q <= rnd_q + 1'b1;
					end
				end
				S_ADD: begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					if (final_q) begin
						state_q <= S_OUT;
					end else if (pad_q) begin
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (load_out) begin
						h_q[0] <= IV0;
						h_q[1] <= IV1;
						h_q[2] <= IV2;
						h_q[3] <= IV3;
						h_q[4] <= IV4;
						cnt_q <= '0;
						pad_q <= 1'b0;
						first_q <= 1'b0;
						len_ok_q <= 1'b0;
						final_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (load_out) begin
				out_busy_q <= 1'b1;
				out_idx_q <= '0;
			end else if (out_take) begin
				out_idx_q <= out_idx_q + 1'b1;
				if (out_idx_q == LAST_INDEX) begin
					out_busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_byte) begin
			blk_q <= {blk_q[503:0], byte_in};
		end else if (do_round) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (start_blk) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (do_round) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
		if (load_out) begin
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				out_q[i] <= h_q[i];
			end
		end else if (out_take) begin
			for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
				out_q[i] <= out_q[i + 1];
			end
		end
	end

	assign empty = ~out_busy_q;
	assign result.digest_word = out_q[0];
	assign result.word_index = out_idx_q;
	assign result.last_word = (out_idx_q == LAST_INDEX);

`ifndef SYNTHESIS
	a_out_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_busy_q) |=> (state_q == S_OUT))
		else $error("digest bank overwritten while words still wait");
	a_out_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && out_idx_q == LAST_INDEX) |=> !out_busy_q)
		else $error("digest bank still busy after its final word");
	a_fill_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND || state_q == S_ADD || state_q == S_OUT) |-> (fill_q == 6'd0))
		else $error("block fill not at zero during compression");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_busy_q |-> (out_idx_q <= LAST_INDEX))
		else $error("digest word index out of range");
`endif

endmodule

`default_nettype wire

// File: rtl/sha1_stream_hasher_unit.sv
// Top level of the SHA-1 stream hasher: front stage, command queue and hash engine.
//
//   Channel   Direction   Handshake         Word
//   input     into block  push / full       item   (msg_byte, byte_present, end_of_message)
//   result    out         empty / pop       result (digest_word, word_index, last_word)
//
// A word passes through the front register and then the queue; the engine takes one byte word
// a cycle while it is idle, and each 64th byte adds a compression of 80 rounds and one add.
// An end-of-message word adds the padding, a byte a cycle to the end of the block with one or
// two compressions, and a load of the digest into the output bank.
// While the engine compresses or holds an unread digest, the front register and the queue
// (four words by default) take up to five more words before full rises; arst_n resets control.
`default_nettype none

module sha1_stream_hasher_unit #(
	parameter int unsigned CMDQ_DEPTH = sha1sh_pkg::CMDQ_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  sha1sh_pkg::in_word_t  item,
	output logic                  empty,
	input  logic                  pop,
	output sha1sh_pkg::out_word_t result
);
	import sha1sh_pkg::*;

	cmd_push_t q_push;
	cmd_head_t q_head;
	logic      q_full;
	logic      q_pop;

	// The front stage drops words that carry neither a byte nor an end mark.
	sha1sh_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_push (q_push),
		.q_full (q_full)
	);

	// The queue lets the front take a few more bytes while the compression rounds run.
	sha1sh_cmdq #(
		.DEPTH (CMDQ_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.full   (q_full),
		.head   (q_head),
		.pop    (q_pop)
	);

	// The engine owns the block window, padding, rounds and the digest bank.
	sha1sh_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.q_pop  (q_pop),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

`default_nettype wire

// File: tb/tb_sha1_stream_hasher_unit.sv
// Self-checking testbench of the SHA-1 stream hasher: directed and random messages.
module tb_sha1_stream_hasher_unit;
	import sha1sh_pkg::*;

	// Clock, reset and the two handshakes. Every input is known from time zero.
	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	in_word_t  item = '0;
	logic      empty;
	logic      pop = 1'b0;
	out_word_t result;

	sha1_stream_hasher_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	// Words still to be offered on the input side, in order.
	in_word_t pending_words[$];

	// Digest words that the block owes us, oldest first.
	out_word_t digest_expect_q[$];
	out_word_t want;
	int unsigned fail_count = 0;

	// Our own running SHA-1 state: chaining words, the partly filled block and the
	// message length in bits.
	logic [31:0] hash_state [5];
	logic [7:0]  blk_bytes [64];
	int unsigned blk_fill;
	logic [63:0] bit_total;

	// Handshake bookkeeping shared between the clocked processes.
	logic        in_taken = 1'b0;
	int unsigned send_gap = 0;
	int unsigned send_calm = 0;
	int unsigned recv_gap = 0;
	int unsigned recv_calm = 0;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	// A generous ceiling, several times the slowest correct run even if every word closed a
	// message and both sides idled as long as they can.
	initial begin
		#12000000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [31:0] rol32(logic [31:0] x, int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// One 80-round compression of the buffered block into the chaining words.
	function automatic void sha1_compress();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
		for (int i = 16; i < 80; i++)
			w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		e = hash_state[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = K0;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = K1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K2;
			end else begin
				f = b ^ c ^ d;
				k = K3;
			end
			t = rol32(a, 5) + f + e + k + w[i];
			e = d;
			d = c;
			c = rol32(b, 30);
			b = a;
			a = t;
		end
		hash_state[0] += a;
		hash_state[1] += b;
		hash_state[2] += c;
		hash_state[3] += d;
		hash_state[4] += e;
	endfunction

	function automatic void sha1_restart();
		hash_state[0] = IV0;
		hash_state[1] = IV1;
		hash_state[2] = IV2;
		hash_state[3] = IV3;
		hash_state[4] = IV4;
		blk_fill = 0;
		bit_total = '0;
	endfunction

	// Folds one accepted input word into the running hash. An end-of-message word
	// pads the message, finishes it and queues the five digest words it owes.
	function automatic void sha1_take(in_word_t w);
		out_word_t dw;
		if (w.byte_present) begin
			bit_total += 64'd8;
			blk_bytes[blk_fill] = w.msg_byte;
			blk_fill++;
			if (blk_fill == 64) begin
				sha1_compress();
				blk_fill = 0;
			end
		end
		if (w.end_of_message) begin
			blk_bytes[blk_fill] = PAD_MARK;
			blk_fill++;
			// Too little room left for the length: pad out and spend an extra block.
			if (blk_fill > 56) begin
				while (blk_fill < 64) begin
					blk_bytes[blk_fill] = 8'h00;
					blk_fill++;
				end
				sha1_compress();
				blk_fill = 0;
			end
			while (blk_fill < 56) begin
				blk_bytes[blk_fill] = 8'h00;
				blk_fill++;
			end
			for (int i = 0; i < 8; i++)
				blk_bytes[56+i] = bit_total[63-8*i -: 8];
			sha1_compress();
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				dw.digest_word = hash_state[i];
				dw.word_index = 3'(i);
				dw.last_word = (3'(i) == LAST_INDEX);
				digest_expect_q.push_back(dw);
			end
			sha1_restart();
		end
	endfunction

	function automatic void add_word(logic [7:0] b, logic present, logic eom);
		in_word_t w;
		w.msg_byte = b;
		w.byte_present = present;
		w.end_of_message = eom;
		pending_words.push_back(w);
	endfunction

	// Idle length between words. Most gaps are nil or short, a few are long, and now
	// and then a calm stretch with no idling at all begins.
	function automatic int unsigned pick_gap(inout int unsigned calm);
		int unsigned r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 62)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Sampling at the rising edge: first the result side is checked, then an accepted
	// input word is folded into the prediction. A digest cannot come out on the edge
	// that takes the word which caused it, so the order is safe.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (digest_expect_q.size() == 0) begin
				$error("unexpected digest word %h (index %0d)", result.digest_word,
					result.word_index);
				fail_count++;
			end else begin
				want = digest_expect_q.pop_front();
				if (result.digest_word !== want.digest_word) begin
					$error("digest_word: expected %h, got %h", want.digest_word,
						result.digest_word);
					fail_count++;
				end
				if (result.word_index !== want.word_index) begin
					$error("word_index: expected %0d, got %0d", want.word_index,
						result.word_index);
					fail_count++;
				end
				if (result.last_word !== want.last_word) begin
					$error("last_word: expected %b, got %b", want.last_word,
						result.last_word);
					fail_count++;
				end
			end
		end
		in_taken = arst_n && push && !full;
		if (in_taken)
			sha1_take(item);
	end

	// Sender: holds the current word until it is taken, then either idles for a while
	// or presents the next pending word. push is assigned at most once per falling edge.
	always @(negedge clk) begin
		if (arst_n && (in_taken || !push)) begin
			if (send_gap > 0) begin
				send_gap--;
				push <= 1'b0;
			end else if (pending_words.size() > 0) begin
				item <= pending_words.pop_front();
				push <= 1'b1;
				send_gap = pick_gap(send_calm);
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off as soon as the first digest is
	// waiting. During the hold the sender keeps offering words, so the output bank,
	// the engine and then the input queue back up until full is raised.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (!hold_done && !empty) begin
				hold_done = 1'b1;
				hold_left = 1500;
				pop <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				recv_gap = pick_gap(recv_calm);
			end
		end
	end

	initial begin
		int unsigned len;
		int unsigned rand_items;
		int unsigned rand_msgs;
		int unsigned specials [10];

		sha1_restart();
		for (int i = 0; i < 64; i++)
			blk_bytes[i] = 8'h00;

		// Directed part. A word with neither byte nor end is ignored; the empty message comes
		// once before and once after abc to show that the state is restored after a digest.
		add_word(8'h3C, 1'b0, 1'b0);
		add_word(8'hA5, 1'b0, 1'b1);
		add_word(8'h61, 1'b1, 1'b0);
		add_word(8'h62, 1'b1, 1'b0);
		add_word(8'h63, 1'b1, 1'b1);
		add_word(8'hFF, 1'b0, 1'b1);
		// The same short message, but closed by a separate end word without a byte.
		add_word(8'h61, 1'b1, 1'b0);
		add_word(8'h62, 1'b1, 1'b0);
		add_word(8'h63, 1'b1, 1'b0);
		add_word(8'h00, 1'b0, 1'b1);
		// Extreme byte values, each as a one-byte message.
		add_word(8'h00, 1'b1, 1'b1);
		add_word(8'hFF, 1'b1, 1'b1);
		// Alternating bit patterns with an ignored word in the middle of the message.
		add_word(8'h55, 1'b1, 1'b0);
		add_word(8'hAA, 1'b1, 1'b0);
		add_word(8'hC3, 1'b0, 1'b0);
		add_word(8'hFF, 1'b1, 1'b0);
		add_word(8'h00, 1'b1, 1'b1);
		add_word(8'h80, 1'b1, 1'b0);
		add_word(8'h01, 1'b1, 1'b0);
		add_word(8'h7F, 1'b0, 1'b1);

		// Random part: whole messages with random content. Lengths lean towards the
		// ones that matter for padding: just below, at and above the point where the
		// length no longer fits, and block boundaries. Ignored words are scattered in
		// as noise and do not count towards the total.
		specials[0] = 55;
		specials[1] = 56;
		specials[2] = 57;
		specials[3] = 62;
		specials[4] = 63;
		specials[5] = 64;
		specials[6] = 65;
		specials[7] = 119;
		specials[8] = 120;
		specials[9] = 128;
		rand_items = 0;
		rand_msgs = 0;
		while (rand_items < 350 || rand_msgs < 12) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: len = $urandom_range(0, 8);
				4, 5, 6: len = specials[$urandom_range(0, 9)];
				default: len = $urandom_range(0, 130);
			endcase
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 9) == 0)
					add_word(8'($urandom), 1'b0, 1'b0);
				// The last byte carries the end flag about half the time.
				add_word(8'($urandom), 1'b1, (i == len - 1) && $urandom_range(0, 1));
				rand_items++;
			end
			if (len == 0 || !pending_words[$].end_of_message) begin
				add_word(8'($urandom), 1'b0, 1'b1);
				rand_items++;
			end
			rand_msgs++;
		end

		// Reset once, released on a falling edge.
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Everything offered and taken, then every digest word back, then a quiet
		// spell long enough for two compressions to show any stray output.
		wait (pending_words.size() == 0 && !push);
		wait (digest_expect_q.size() == 0);
		repeat (400) @(posedge clk);
		if (fail_count == 0 && digest_expect_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
